// ----- design/fba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;
    localparam int BLOCKS_IN_USE_RESET = 16;

    // Fit modes; the unused code behaves as first fit
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // Transaction function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        logic        func;
        logic [3:0]  load_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
    } in_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_index;
        logic [15:0] remaining;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- design/fba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire fba_pkg::status_t status,
    output fba_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/fba_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fba_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [fba_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [fba_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire fba_pkg::in_t                        s_data,
    input  wire fba_pkg::cmd_t                       cmd,
    output fba_pkg::status_t                         status,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output fba_pkg::out_t                            m_data
);

    localparam int NB = fba_pkg::NUM_BLOCKS;
    localparam int IW = fba_pkg::IDX_BITS;
    localparam int CW = fba_pkg::CNT_BITS;

    // Configuration
    logic [1:0] fit_mode_reg;
    logic [4:0] blocks_in_use_reg;

    // Captured transaction
    logic             func_reg;
    logic [3:0]       load_index_reg;
    fba_pkg::size_t   block_size_reg;
    fba_pkg::size_t   request_reg;

    // Search state
    logic [CW-1:0]    scan_reg;
    logic             found_reg;
    logic [IW-1:0]    pick_reg;
    fba_pkg::size_t   left_reg;

    // Free size table and output register
    fba_pkg::size_t   table_reg [NB];
    logic             m_valid_reg;
    fba_pkg::out_t    m_data_reg;

    logic             mode_first;
    logic [CW-1:0]    count;
    fba_pkg::size_t   cur_size;
    fba_pkg::size_t   cur_left;
    logic             fits;
    logic             take;
    logic             load_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg      <= fba_pkg::MODE_FIRST;
            blocks_in_use_reg <= 5'(fba_pkg::BLOCKS_IN_USE_RESET);
        end else if (cfg_we) begin
            if (cfg_index == fba_pkg::CFG_FIT_MODE) begin
                fit_mode_reg <= cfg_data[1:0];
            end else if (cfg_index == fba_pkg::CFG_BLOCKS_IN_USE) begin
                blocks_in_use_reg <= cfg_data[4:0];
            end
        end
    end

    // Search decode
    assign mode_first = (fit_mode_reg != fba_pkg::MODE_BEST) &&
                        (fit_mode_reg != fba_pkg::MODE_WORST);
    assign count = (32'(blocks_in_use_reg) > NB) ? CW'(NB) : CW'(blocks_in_use_reg);
    assign cur_size = table_reg[scan_reg[IW-1:0]];
    assign fits     = (request_reg <= cur_size);
    assign cur_left = cur_size - request_reg;

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (fit_mode_reg == fba_pkg::MODE_BEST) begin
                take = (cur_left < left_reg);
            end else if (fit_mode_reg == fba_pkg::MODE_WORST) begin
                take = (cur_left > left_reg);
            end
        end
    end

    assign load_in_range = (32'(load_index_reg) < NB);

    assign status.scan_done = (func_reg == fba_pkg::FUNC_LOAD) || (scan_reg == count) ||
                              (mode_first && found_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    // Capture and scan
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            func_reg       <= s_data.func;
            load_index_reg <= s_data.load_index;
            block_size_reg <= fba_pkg::SIZE_BITS'(s_data.block_size);
            request_reg    <= fba_pkg::SIZE_BITS'(s_data.request_size);
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            pick_reg       <= '0;
            left_reg       <= '0;
        end else if (cmd.step) begin
            scan_reg <= scan_reg + CW'(1);
            if (take) begin
                found_reg <= 1'b1;
                pick_reg  <= scan_reg[IW-1:0];
                left_reg  <= cur_left;
            end
        end
    end

    // Table write back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) begin
                table_reg[i] <= '0;
            end
        end else if (cmd.finish) begin
            if (func_reg == fba_pkg::FUNC_LOAD) begin
                if (load_in_range) begin
                    table_reg[IW'(load_index_reg)] <= block_size_reg;
                end
            end else if (found_reg) begin
                table_reg[pick_reg] <= left_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (func_reg == fba_pkg::FUNC_LOAD) begin
                m_data_reg.granted      <= 1'b0;
                m_data_reg.chosen_index <= load_index_reg;
                m_data_reg.remaining    <= load_in_range ? 16'(block_size_reg) : 16'd0;
            end else begin
                m_data_reg.granted      <= found_reg;
                m_data_reg.chosen_index <= found_reg ? 4'(pick_reg) : 4'd0;
                m_data_reg.remaining    <= found_reg ? 16'(left_reg) : 16'd0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- design/fit_block_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                         | Contents
// input    | s_valid, s_ready, s_data      | func, load_index, block_size, request_size
// result   | m_valid, m_ready, m_data      | granted, chosen_index, remaining
// config   | cfg_we, cfg_index, cfg_data   | 0 fit_mode, 1 blocks_in_use
//
// One transaction at a time: the controller accepts it in ST_IDLE, scans the table
// entries one by one in ST_SCAN (up to blocks_in_use, 16 at most; first fit stops
// at the first hit) until it sees the scan end, then writes back in ST_FINISH. A
// load skips the scan. The scan goes through the single table read port.
// Synchronous active-low reset clears the table to zero and the config to defaults.
// A pending result is held in the output register; the next transaction is
// accepted meanwhile and waits at write-back until that result is taken.

module fit_block_allocator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [fba_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [fba_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire fba_pkg::in_t                      s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output fba_pkg::out_t                          m_data
);

    fba_pkg::cmd_t    cmd;
    fba_pkg::status_t status;

    fba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fba_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/fba_alloc_checker.sv -----
`timescale 1ns / 1ps

// Watches the request and result channels of the fit block allocator, keeps its
// own copy of the free-size table and settings, and compares every result.
module fba_alloc_checker
    import fba_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_t                      s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_t                     m_data,
    output int                       mismatch_count,
    output int                       outcomes_awaited
);

    size_t                    free_sizes [NUM_BLOCKS];
    logic [1:0]               fit_mode;
    logic [CFG_DATA_BITS-1:0] blocks_in_use;
    out_t                     awaited_outcomes [$];
    out_t                     want;
    int                       errors = 0;

    initial begin
        mismatch_count   = 0;
        outcomes_awaited = 0;
    end

    // Work out one transaction's result and update the table the same way
    function automatic out_t allocate_or_load(in_t item);
        out_t  outcome;
        int    count;
        bit    found;
        int    pick;
        size_t left;
        size_t pick_left;
        outcome   = '0;
        found     = 1'b0;
        pick      = 0;
        pick_left = '0;
        if (item.func == FUNC_LOAD) begin
            outcome.chosen_index = item.load_index;
            if (item.load_index < NUM_BLOCKS) begin
                free_sizes[item.load_index] = item.block_size;
                outcome.remaining = item.block_size;
            end
            return outcome;
        end
        // Out-of-range counts clamp to the table size
        count = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
        for (int j = 0; j < count; j++) begin
            if (item.request_size > free_sizes[IDX_BITS'(j)])
                continue;
            left = free_sizes[IDX_BITS'(j)] - item.request_size;
            if (!found) begin
                found     = 1'b1;
                pick      = j;
                pick_left = left;
                // First fit, and the unused mode, stop at the lowest hit
                if (fit_mode != MODE_BEST && fit_mode != MODE_WORST)
                    break;
            end else if (fit_mode == MODE_BEST && left < pick_left) begin
                pick      = j;
                pick_left = left;
            end else if (fit_mode == MODE_WORST && left > pick_left) begin
                pick      = j;
                pick_left = left;
            end
        end
        if (found) begin
            free_sizes[IDX_BITS'(pick)] = pick_left;
            outcome.granted      = 1'b1;
            outcome.chosen_index = 4'(pick);
            outcome.remaining    = pick_left;
        end
        return outcome;
    endfunction

    task automatic check_field(string field, int unsigned expected_val, int unsigned got);
        if (expected_val != got) begin
            errors++;
            $display("%0d ns: %s mismatch, expected %0d, got %0d",
                     $time, field, expected_val, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (free_sizes[i])
                free_sizes[i] = '0;
            fit_mode      = MODE_FIRST;
            blocks_in_use = CFG_DATA_BITS'(BLOCKS_IN_USE_RESET);
            awaited_outcomes.delete();
        end else begin
            // Register writes; unknown indexes are ignored
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIT_MODE:      fit_mode = cfg_data[1:0];
                    CFG_BLOCKS_IN_USE: blocks_in_use = cfg_data;
                    default: ;
                endcase
            end
            // Result side first, so a stray result is never matched to a new push
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    errors++;
                    $display("%0d ns: unexpected result, expected none, got %0d/%0d/%0d",
                             $time, m_data.granted, m_data.chosen_index, m_data.remaining);
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("granted", 32'(want.granted), 32'(m_data.granted));
                    check_field("chosen_index", 32'(want.chosen_index),
                                32'(m_data.chosen_index));
                    check_field("remaining", 32'(want.remaining), 32'(m_data.remaining));
                end
            end
            if (s_valid && s_ready)
                awaited_outcomes.push_back(allocate_or_load(s_data));
        end
        mismatch_count   <= errors;
        outcomes_awaited <= awaited_outcomes.size();
    end

endmodule

// ----- tb/sv/fit_block_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module fit_block_allocator_top_tb;
    import fba_pkg::*;

    localparam logic [1:0]              MODE_SPARE      = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int                      HOLD_CYCLES     = 400;
    localparam int                      SEGMENTS        = 8;
    localparam int                      SEGMENT_ITEMS   = 130;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_t                      s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_t                     m_data;

    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;
    int   mismatch_count;
    int   outcomes_awaited;

    fit_block_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    fba_alloc_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatch_count   (mismatch_count),
        .outcomes_awaited (outcomes_awaited)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic in_t load_entry(logic [3:0] index, size_t size);
        in_t item;
        item            = '0;
        item.func       = FUNC_LOAD;
        item.load_index = index;
        item.block_size = size;
        return item;
    endfunction

    function automatic in_t request(size_t size);
        in_t item;
        item              = '0;
        item.func         = FUNC_ALLOC;
        item.request_size = size;
        return item;
    endfunction

    // Sizes lean small and onto multiples of 16 so that ties and misses are common
    function automatic in_t random_item();
        in_t         item;
        int unsigned pick;
        item.func       = ($urandom_range(0, 99) < 35) ? FUNC_LOAD : FUNC_ALLOC;
        item.load_index = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            item.block_size = 16'(16 * $urandom_range(0, 4));
        else if (pick < 8)
            item.block_size = 16'($urandom_range(0, 255));
        else if (pick == 8)
            item.block_size = 16'(32'hFFFF - $urandom_range(0, 3));
        else
            item.block_size = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            item.request_size = '0;
        else if (pick < 7)
            item.request_size = 16'($urandom_range(0, 80));
        else if (pick < 9)
            item.request_size = 16'($urandom_range(0, 300));
        else
            item.request_size = 16'($urandom_range(0, 65535));
        return item;
    endfunction

    task automatic send_item(in_t item);
        while (!no_idle && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outcomes_awaited != 0);
    endtask

    // Writes both registers, then the unused index with junk data
    task automatic set_config(logic [1:0] mode, logic [CFG_DATA_BITS-1:0] count);
        logic [CFG_DATA_BITS-1:0] junk;
        junk      = CFG_DATA_BITS'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIT_MODE;
        cfg_data  <= {junk[CFG_DATA_BITS-1:2], mode};
        @(posedge aclk);
        cfg_index <= CFG_BLOCKS_IN_USE;
        cfg_data  <= count;
        @(posedge aclk);
        cfg_index <= CFG_SPARE_INDEX;
        cfg_data  <= junk;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // Stimulus
    initial begin
        logic [1:0]               mode;
        logic [CFG_DATA_BITS-1:0] count;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings, first fit: zero request on an empty table, then a miss
        send_item(request(16'd0));
        send_item(request(16'hFFFF));
        send_item(load_entry(4'd0, 16'd30));
        send_item(load_entry(4'd5, 16'd100));
        send_item(load_entry(4'd9, 16'd100));
        send_item(load_entry(4'd7, 16'd300));
        send_item(load_entry(4'd15, 16'hFFFF));
        send_item(load_entry(4'd3, 16'd0));
        send_item(request(16'd50));

        // Best fit over the whole table, including the full-size request
        drain();
        set_config(MODE_BEST, 5'd16);
        send_item(request(16'd60));
        send_item(request(16'd40));
        send_item(request(16'hFFFF));

        // Worst fit over the lower half
        drain();
        set_config(MODE_WORST, 5'd8);
        send_item(request(16'd10));
        send_item(request(16'd400));

        // Unused mode with nothing searched
        drain();
        set_config(MODE_SPARE, 5'd0);
        send_item(request(16'd0));

        // Unused mode acts as first fit; count above the table size
        drain();
        set_config(MODE_SPARE, 5'd31);
        send_item(load_entry(4'd15, 16'd5));
        send_item(request(16'd5));

        // Single entry searched
        drain();
        set_config(MODE_BEST, 5'd1);
        send_item(request(16'd25));
        send_item(request(16'd1));

        // Random segments, each with its own settings
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       count = 5'd16;
                1:       count = 5'd1;
                2:       count = 5'($urandom_range(17, 31));
                default: count = 5'($urandom_range(2, 16));
            endcase
            set_config(mode, count);
            no_idle <= (seg == 3);
            if (seg == 1)
                hold_request <= 1'b1;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_item(random_item());
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fba_pkg.sv
design/fba_ctrl.sv
design/fba_datapath.sv
design/fit_block_allocator_top.sv
tb/sv/fba_alloc_checker.sv
tb/sv/fit_block_allocator_top_tb.sv
